// ===== hw/rtl/tempo_synced_loop_overdub_mixer_unit_assert.svh =====
// assertion macros for the loop mixer
`ifndef TEMPO_SYNCED_LOOP_OVERDUB_MIXER_UNIT_ASSERT_SVH
`define TEMPO_SYNCED_LOOP_OVERDUB_MIXER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define TSLOM_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`define TSLOM_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");
`else
`define TSLOM_NEVER(label, clk, rst, expr)
`define TSLOM_IMPLIES(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/tslom_pkg.sv =====
// shared constants, types and saturation functions of the loop mixer
package tslom_pkg;

   localparam int CHANNEL_COUNT = 4;
   localparam int STORE_DEPTH   = 262144;
   localparam int SAMPLE_BITS   = 24;

   localparam int SEL_W    = 3;
   localparam int IO_W     = 24;
   localparam int TIME_W   = 48;
   localparam int BARS_W   = 8;
   localparam int RATE_W   = 19;
   localparam int BPM_W    = 10;
   localparam int PROD_W   = BARS_W + RATE_W;
   localparam int PER_W    = PROD_W + 8;
   localparam int MEM_DEPTH = CHANNEL_COUNT * STORE_DEPTH;
   localparam int POS_W    = $clog2(STORE_DEPTH);
   localparam int ADDR_W   = $clog2(MEM_DEPTH);
   localparam int ACC_W    = ((SAMPLE_BITS > IO_W) ? SAMPLE_BITS : IO_W) + 4;
   localparam int DCNT_W   = $clog2(TIME_W + 1);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [3:0] CH_MASK =
      (CHANNEL_COUNT >= 4) ? 4'hF : 4'((1 << CHANNEL_COUNT) - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ENABLE = 3'd0,
      REG_SOLO   = 3'd1,
      REG_RECORD = 3'd2,
      REG_TEMPO  = 3'd3,
      REG_RATE   = 3'd4,
      REG_BARS   = 3'd5,
      REG_PLAY   = 3'd6,
      REG_CLEAR  = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic             load_in;
      logic             sweep_all;
      logic             take_clear;
      logic             mul;
      logic             div_period;
      logic             cap_period;
      logic             div_pos;
      logic             rd;
      logic             acc;
      logic             wr;
      logic             out_load;
      logic [SEL_W-1:0] ch;
   } cmd_type;

   typedef struct packed {
      logic             enable;
      logic             solo_on;
      logic [SEL_W-1:0] solo_ch;
      logic             rec_on;
      logic [SEL_W-1:0] rec_ch;
      logic             play_bit;
      logic             pend_bit;
      logic             sweep_busy;
      logic             div_busy;
      logic             period_zero;
      logic             pos_ok;
      logic             out_free;
   } stat_type;

   localparam logic signed [IO_W-1:0] OUT_MAX = {1'b0, {(IO_W-1){1'b1}}};
   localparam logic signed [IO_W-1:0] OUT_MIN = {1'b1, {(IO_W-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   function automatic logic signed [IO_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
      logic signed [IO_W-1:0] r;
      if (v > ACC_W'(OUT_MAX)) begin
         r = OUT_MAX;
      end else if (v < ACC_W'(OUT_MIN)) begin
         r = OUT_MIN;
      end else begin
         r = v[IO_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
      input logic signed [ACC_W-1:0] v);
      logic signed [SAMPLE_BITS-1:0] r;
      if (v > ACC_W'(SMP_MAX)) begin
         r = SMP_MAX;
      end else if (v < ACC_W'(SMP_MIN)) begin
         r = SMP_MIN;
      end else begin
         r = v[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/tempo_synced_loop_overdub_mixer_unit.sv =====
// top level of the tempo synced stereo loop mixer with overdub
//
// req_ carries one stereo Q1.23 sample and its time index per beat; rsp_
// returns one saturated stereo sample per request beat, in order. csr_
// writes one register per beat and is always ready; write only while idle.
// One request is worked on at a time. The work of each channel that plays
// is dominated by two passes of the one-bit-per-cycle divider (loop
// period, then position); the overdub pass does the same. A pending
// clear that is taken adds a sweep of that channel's 262144 store
// entries, one entry per cycle. After reset the whole store (1048576
// entries) is zeroed one entry per cycle before the first request is
// taken; req_stall stays high meanwhile. A finished result waits in the
// output register while rsp_stall is high; the next request is accepted
// in the meantime and waits for it at the end.
module tempo_synced_loop_overdub_mixer_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [tslom_pkg::IO_W-1:0] req_left_in,
   input  logic signed [tslom_pkg::IO_W-1:0] req_right_in,
   input  logic [tslom_pkg::TIME_W-1:0]      req_time_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [tslom_pkg::IO_W-1:0] rsp_left_out,
   output logic signed [tslom_pkg::IO_W-1:0] rsp_right_out,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tslom_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tslom_pkg::CSR_DATA_W-1:0]  csr_data
);
   import tslom_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   tslom_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_left_in    (req_left_in),
      .req_right_in   (req_right_in),
      .req_time_index (req_time_index),
      .rsp_stall      (rsp_stall),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_left_out   (rsp_left_out),
      .rsp_right_out  (rsp_right_out)
   );

   tslom_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

endmodule

// ===== hw/rtl/tslom_div.sv =====
// restoring divider, one quotient bit per cycle
module tslom_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tslom_pkg::TIME_W-1:0]  dividend,
   input  logic [tslom_pkg::PER_W-1:0]   divisor,
   output logic                          busy,
   output logic [tslom_pkg::TIME_W-1:0]  quotient,
   output logic [tslom_pkg::PER_W-1:0]   remainder
);
   import tslom_pkg::*;

   logic                busy_ff, busy_in;
   logic [DCNT_W-1:0]   cnt_ff, cnt_in;
   logic [TIME_W-1:0]   quo_ff, quo_in;
   logic [PER_W-1:0]    rem_ff, rem_in;
   logic [PER_W-1:0]    dsr_ff, dsr_in;
   logic [PER_W:0]      rem_sh;
   logic [PER_W:0]      rem_sub;
   logic                ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[TIME_W-1]};
      ge      = rem_sh >= {1'b0, dsr_ff};
      rem_sub = rem_sh - {1'b0, dsr_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(TIME_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[TIME_W-2:0], ge};
         rem_in = ge ? rem_sub[PER_W-1:0] : rem_sh[PER_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/tslom_dp.sv =====
// datapath: registers, loop position arithmetic, sample stores and mixing
module tslom_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [tslom_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tslom_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic signed [tslom_pkg::IO_W-1:0] req_left_in,
   input  logic signed [tslom_pkg::IO_W-1:0] req_right_in,
   input  logic [tslom_pkg::TIME_W-1:0]      req_time_index,
   input  logic                              rsp_stall,
   input  tslom_pkg::cmd_type                cmd,
   output tslom_pkg::stat_type               stat,
   output logic                              rsp_valid,
   output logic signed [tslom_pkg::IO_W-1:0] rsp_left_out,
   output logic signed [tslom_pkg::IO_W-1:0] rsp_right_out
);
   import tslom_pkg::*;

   logic              enable_ff;
   logic [SEL_W-1:0]  solo_ff;
   logic [SEL_W-1:0]  record_ff;
   logic [BPM_W-1:0]  bpm_ff;
   logic [RATE_W-1:0] rate_ff;
   logic [31:0]       bars_ff;
   logic [3:0]        play_ff;
   logic [3:0]        pend_ff, pend_in;

   logic signed [IO_W-1:0] lin_ff, rin_ff;
   logic [TIME_W-1:0]      t_ff;
   logic signed [ACC_W-1:0] l_ff, r_ff;
   logic [PROD_W-1:0]      prod_ff;
   logic [PER_W-1:0]       period_ff;

   logic                   sweep_ff;
   logic [ADDR_W-1:0]      sweep_addr_ff, sweep_end_ff;

   logic signed [SAMPLE_BITS-1:0] left_mem  [MEM_DEPTH];
   logic signed [SAMPLE_BITS-1:0] right_mem [MEM_DEPTH];
   logic signed [SAMPLE_BITS-1:0] rdl_ff, rdr_ff;

   logic                   out_valid_ff;
   logic signed [IO_W-1:0] out_l_ff, out_r_ff;

   logic                   csr_wr;
   logic                   ch_low;
   logic [BARS_W-1:0]      bars;
   logic [BPM_W-1:0]       bpm_eff;
   logic [PER_W-1:0]       scaled;
   logic                   div_start, div_busy;
   logic [TIME_W-1:0]      div_dividend, div_quo;
   logic [PER_W-1:0]       div_divisor, div_rem;
   logic [ADDR_W-1:0]      ch_base, rw_addr, wr_addr;
   logic                   we;
   logic signed [SAMPLE_BITS-1:0] wl, wr_r;
   logic signed [ACC_W-1:0] od_l, od_r;

   assign csr_wr  = csr_valid;
   assign ch_low  = cmd.ch < SEL_W'(4);
   assign bars    = ch_low ? bars_ff[{cmd.ch[1:0], 3'b000} +: BARS_W] : '0;
   assign bpm_eff = (bpm_ff == '0) ? BPM_W'(1) : bpm_ff;
   assign scaled  = (PER_W'(prod_ff) << 8) - (PER_W'(prod_ff) << 4);

   always_comb begin
      pend_in = pend_ff;
      if (csr_wr && (csr_index == REG_CLEAR)) begin
         pend_in = pend_ff | (csr_data[3:0] & CH_MASK);
      end
      if (cmd.take_clear && ch_low) begin
         pend_in[cmd.ch[1:0]] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         solo_ff   <= SEL_W'(4);
         record_ff <= SEL_W'(4);
         bpm_ff    <= BPM_W'(120);
         rate_ff   <= RATE_W'(48000);
         bars_ff   <= 32'd67372036;
         play_ff   <= '0;
         pend_ff   <= '0;
      end else begin
         pend_ff <= pend_in;
         if (csr_wr) begin
            case (reg_index_type'(csr_index))
               REG_ENABLE: begin
                  enable_ff <= csr_data[0];
               end
               REG_SOLO: begin
                  solo_ff <= csr_data[SEL_W-1:0];
               end
               REG_RECORD: begin
                  record_ff <= csr_data[SEL_W-1:0];
               end
               REG_TEMPO: begin
                  bpm_ff <= csr_data[BPM_W-1:0];
               end
               REG_RATE: begin
                  rate_ff <= csr_data[RATE_W-1:0];
               end
               REG_BARS: begin
                  bars_ff <= csr_data;
               end
               REG_PLAY: begin
                  play_ff <= csr_data[3:0] & CH_MASK;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // loop period and position
   assign div_start    = cmd.div_period | cmd.div_pos;
   assign div_dividend = cmd.div_period ? TIME_W'(scaled) : t_ff;
   assign div_divisor  = cmd.div_period ? PER_W'(bpm_eff) : period_ff;

   tslom_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= PROD_W'(bars) * PROD_W'(rate_ff);
      end
      if (cmd.cap_period) begin
         period_ff <= div_quo[PER_W-1:0];
      end
   end

   // input beat and mix accumulators
   assign od_l = ACC_W'(rdl_ff) + ACC_W'(lin_ff);
   assign od_r = ACC_W'(rdr_ff) + ACC_W'(rin_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         lin_ff <= req_left_in;
         rin_ff <= req_right_in;
         t_ff   <= req_time_index;
         l_ff   <= ACC_W'(req_left_in);
         r_ff   <= ACC_W'(req_right_in);
      end else if (cmd.acc) begin
         l_ff <= l_ff + ACC_W'(rdl_ff);
         r_ff <= r_ff + ACC_W'(rdr_ff);
      end
   end

   // clearing sweep
   assign ch_base = ADDR_W'(cmd.ch) * ADDR_W'(STORE_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= 1'b0;
      end else if (cmd.sweep_all || cmd.take_clear) begin
         sweep_ff <= 1'b1;
      end else if (sweep_ff && (sweep_addr_ff == sweep_end_ff)) begin
         sweep_ff <= 1'b0;
      end
      if (cmd.sweep_all) begin
         sweep_addr_ff <= '0;
         sweep_end_ff  <= ADDR_W'(MEM_DEPTH - 1);
      end else if (cmd.take_clear) begin
         sweep_addr_ff <= ch_base;
         sweep_end_ff  <= ch_base + ADDR_W'(STORE_DEPTH - 1);
      end else if (sweep_ff) begin
         sweep_addr_ff <= sweep_addr_ff + 1'b1;
      end
   end

   // sample stores
   assign rw_addr = ch_base + ADDR_W'(div_rem[POS_W-1:0]);
   assign we      = sweep_ff | cmd.wr;
   assign wr_addr = sweep_ff ? sweep_addr_ff : rw_addr;
   assign wl      = sweep_ff ? '0 : sat_smp(od_l);
   assign wr_r    = sweep_ff ? '0 : sat_smp(od_r);

   always_ff @(posedge clock) begin
      if (we) begin
         left_mem[wr_addr]  <= wl;
         right_mem[wr_addr] <= wr_r;
      end
      if (cmd.rd) begin
         rdl_ff <= left_mem[rw_addr];
         rdr_ff <= right_mem[rw_addr];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         out_l_ff <= sat_out(l_ff);
         out_r_ff <= sat_out(r_ff);
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_left_out  = out_l_ff;
   assign rsp_right_out = out_r_ff;

   always_comb begin
      stat.enable      = enable_ff;
      stat.solo_on     = {1'b0, solo_ff} < (SEL_W + 1)'(CHANNEL_COUNT);
      stat.solo_ch     = solo_ff;
      stat.rec_on      = {1'b0, record_ff} < (SEL_W + 1)'(CHANNEL_COUNT);
      stat.rec_ch      = record_ff;
      stat.play_bit    = ch_low ? play_ff[cmd.ch[1:0]] : 1'b0;
      stat.pend_bit    = ch_low ? pend_ff[cmd.ch[1:0]] : 1'b0;
      stat.sweep_busy  = sweep_ff;
      stat.div_busy    = div_busy;
      stat.period_zero = period_ff == '0;
      stat.pos_ok      = div_rem < PER_W'(STORE_DEPTH);
      stat.out_free    = !out_valid_ff || !rsp_stall;
   end

   `include "tempo_synced_loop_overdub_mixer_unit_assert.svh"

   `TSLOM_NEVER(a_sweep_vs_overdub, clock, reset, sweep_ff && (cmd.wr || cmd.rd))
   `TSLOM_NEVER(a_div_restart, clock, reset, div_start && div_busy)
   `TSLOM_IMPLIES(a_out_no_overrun, clock, reset, cmd.out_load, !out_valid_ff || !rsp_stall)

endmodule

// ===== hw/rtl/tslom_ctrl.sv =====
// controller: sequences clears, position arithmetic, playback and overdub per beat
module tslom_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  tslom_pkg::stat_type  stat,
   output tslom_pkg::cmd_type   cmd,
   output logic                 req_stall
);
   import tslom_pkg::*;

   typedef enum logic [14:0] {
      S_BOOT  = 15'b000000000000001,
      S_INIT  = 15'b000000000000010,
      S_IDLE  = 15'b000000000000100,
      S_CHK   = 15'b000000000001000,
      S_CLR   = 15'b000000000010000,
      S_MUL   = 15'b000000000100000,
      S_SCALE = 15'b000000001000000,
      S_DIVP  = 15'b000000010000000,
      S_PER   = 15'b000000100000000,
      S_DIVM  = 15'b000001000000000,
      S_RD    = 15'b000010000000000,
      S_USE   = 15'b000100000000000,
      S_NEXT  = 15'b001000000000000,
      S_REC   = 15'b010000000000000,
      S_DONE  = 15'b100000000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [SEL_W-1:0] ch_ff, ch_in;
   logic             single_ff, single_in;
   logic             rec_ff, rec_in;

   always_comb begin
      state_in  = state_ff;
      ch_in     = ch_ff;
      single_in = single_ff;
      rec_in    = rec_ff;
      cmd       = '0;
      cmd.ch    = ch_ff;
      case (state_ff)
         S_BOOT: begin
            cmd.sweep_all = 1'b1;
            state_in      = S_INIT;
         end
         S_INIT: begin
            if (!stat.sweep_busy) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               rec_in      = 1'b0;
               if (!stat.enable) begin
                  state_in = S_DONE;
               end else if (stat.solo_on) begin
                  ch_in     = stat.solo_ch;
                  single_in = 1'b1;
                  state_in  = S_CHK;
               end else begin
                  ch_in     = '0;
                  single_in = 1'b0;
                  state_in  = S_CHK;
               end
            end
         end
         S_CHK: begin
            if (!stat.play_bit) begin
               state_in = S_NEXT;
            end else if (stat.pend_bit) begin
               cmd.take_clear = 1'b1;
               state_in       = S_CLR;
            end else begin
               state_in = S_MUL;
            end
         end
         S_CLR: begin
            if (!stat.sweep_busy) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.div_period = 1'b1;
            state_in       = S_DIVP;
         end
         S_DIVP: begin
            if (!stat.div_busy) begin
               cmd.cap_period = 1'b1;
               state_in       = S_PER;
            end
         end
         S_PER: begin
            if (stat.period_zero) begin
               state_in = rec_ff ? S_DONE : S_NEXT;
            end else begin
               cmd.div_pos = 1'b1;
               state_in    = S_DIVM;
            end
         end
         S_DIVM: begin
            if (!stat.div_busy) begin
               if (stat.pos_ok) begin
                  state_in = S_RD;
               end else begin
                  state_in = rec_ff ? S_DONE : S_NEXT;
               end
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_USE;
         end
         S_USE: begin
            if (rec_ff) begin
               cmd.wr   = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.acc  = 1'b1;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (single_ff || (ch_ff == SEL_W'(CHANNEL_COUNT - 1))) begin
               state_in = S_REC;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = S_CHK;
            end
         end
         S_REC: begin
            if (stat.rec_on) begin
               ch_in    = stat.rec_ch;
               rec_in   = 1'b1;
               state_in = S_MUL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_BOOT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_BOOT;
         ch_ff     <= '0;
         single_ff <= 1'b0;
         rec_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ch_ff     <= ch_in;
         single_ff <= single_in;
         rec_ff    <= rec_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule

// ===== tb/sv/tb_tempo_synced_loop_overdub_mixer_unit.sv =====
// self-checking testbench of the tempo synced loop mixer with overdub
`timescale 1ns / 100ps

module tb_tempo_synced_loop_overdub_mixer_unit;
   import tslom_pkg::*;

   localparam int CYCLE_LIMIT = 20000000;

   typedef struct {
      logic signed [IO_W-1:0] left;
      logic signed [IO_W-1:0] right;
   } stereo_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [IO_W-1:0]        req_left_in;
   logic signed [IO_W-1:0]        req_right_in;
   logic [TIME_W-1:0]             req_time_index;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [IO_W-1:0]        rsp_left_out;
   logic signed [IO_W-1:0]        rsp_right_out;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_IDX_W-1:0]          csr_index;
   logic [CSR_DATA_W-1:0]         csr_data;

   stereo_type mix_expected_q[$];
   int         cycle_count;
   int         error_count;
   int         beats_sent;
   int         beats_checked;
   int         send_idle_pct;
   int         stall_pct;
   int         hold_left;

   // own copy of the registers and stores
   logic                  m_enable;
   logic [SEL_W-1:0]      m_solo;
   logic [SEL_W-1:0]      m_rec;
   logic [BPM_W-1:0]      m_bpm;
   logic [RATE_W-1:0]     m_rate;
   logic [31:0]           m_bars;
   logic [3:0]            m_play;
   logic [3:0]            m_pend;
   int                    left_loop[CHANNEL_COUNT][int];
   int                    right_loop[CHANNEL_COUNT][int];

   tempo_synced_loop_overdub_mixer_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_left_in(req_left_in), .req_right_in(req_right_in),
      .req_time_index(req_time_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_left_out(rsp_left_out), .rsp_right_out(rsp_right_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("[tempo_synced_loop_overdub_mixer_unit] ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic longint clip(input longint v, input int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic bit loop_pos(input int ch, input logic [TIME_W-1:0] t, output int pos);
      longint unsigned bars;
      longint unsigned bpm;
      longint unsigned period;
      longint unsigned p;
      pos = 0;
      bars = (ch < 4) ? longint'(m_bars[8*ch +: 8]) : 0;
      bpm = (m_bpm != 0) ? longint'(m_bpm) : 1;
      period = bars * longint'(m_rate) * 240 / bpm;
      if (period == 0) return 1'b0;
      p = longint'(t) % period;
      if (p >= STORE_DEPTH) return 1'b0;
      pos = int'(p);
      return 1'b1;
   endfunction

   task automatic play_loop(input int ch, input logic [TIME_W-1:0] t,
                            inout longint l, inout longint r);
      int pos;
      if (m_play[ch]) begin
         if (m_pend[ch]) begin
            left_loop[ch].delete();
            right_loop[ch].delete();
            m_pend[ch] = 1'b0;
         end
         if (loop_pos(ch, t, pos)) begin
            if (left_loop[ch].exists(pos)) l += left_loop[ch][pos];
            if (right_loop[ch].exists(pos)) r += right_loop[ch][pos];
         end
      end
   endtask

   task automatic mix_predict(input logic signed [IO_W-1:0] li, input logic signed [IO_W-1:0] ri,
                              input logic [TIME_W-1:0] t, output stereo_type res);
      longint l;
      longint r;
      int     pos;
      int     lold;
      int     rold;
      l = li;
      r = ri;
      if (m_enable) begin
         if (m_solo < CHANNEL_COUNT) begin
            play_loop(m_solo, t, l, r);
         end else begin
            for (int ch = 0; ch < CHANNEL_COUNT; ch++) play_loop(ch, t, l, r);
         end
         if (m_rec < CHANNEL_COUNT && loop_pos(m_rec, t, pos)) begin
            lold = left_loop[m_rec].exists(pos) ? left_loop[m_rec][pos] : 0;
            rold = right_loop[m_rec].exists(pos) ? right_loop[m_rec][pos] : 0;
            left_loop[m_rec][pos] = int'(clip(longint'(lold) + li, SAMPLE_BITS));
            right_loop[m_rec][pos] = int'(clip(longint'(rold) + ri, SAMPLE_BITS));
         end
      end
      res.left = IO_W'(clip(l, IO_W));
      res.right = IO_W'(clip(r, IO_W));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (mix_expected_q.size() == 0) begin
            $display("%0t unexpected beat: actual %0d %0d", $time, rsp_left_out, rsp_right_out);
            error_count++;
         end else begin
            if (rsp_left_out !== mix_expected_q[0].left) begin
               $display("%0t left mismatch: expected %0d actual %0d",
                        $time, mix_expected_q[0].left, rsp_left_out);
               error_count++;
            end
            if (rsp_right_out !== mix_expected_q[0].right) begin
               $display("%0t right mismatch: expected %0d actual %0d",
                        $time, mix_expected_q[0].right, rsp_right_out);
               error_count++;
            end
            void'(mix_expected_q.pop_front());
            beats_checked++;
         end
      end
   end

   task automatic send_sample(input logic signed [IO_W-1:0] l, input logic signed [IO_W-1:0] r,
                              input logic [TIME_W-1:0] t);
      stereo_type res;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_left_in <= l;
      req_right_in <= r;
      req_time_index <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mix_predict(l, r, t, res);
      mix_expected_q.push_back(res);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(negedge clock);
      while (mix_expected_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_ENABLE: m_enable = value[0];
         REG_SOLO:   m_solo = value[SEL_W-1:0];
         REG_RECORD: m_rec = value[SEL_W-1:0];
         REG_TEMPO:  m_bpm = value[BPM_W-1:0];
         REG_RATE:   m_rate = value[RATE_W-1:0];
         REG_BARS:   m_bars = value;
         REG_PLAY:   m_play = value[3:0] & CH_MASK;
         REG_CLEAR:  m_pend = m_pend | (value[3:0] & CH_MASK);
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [TIME_W-1:0] rand_time();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[TIME_W-1:0];
   endfunction

   task automatic test_passthrough;
      send_sample(OUT_MAX, OUT_MIN, '0);
      send_sample(OUT_MIN, OUT_MAX, '1);
      send_sample('0, -1, rand_time());
      drain();
   endtask

   task automatic test_record_play;
      // short loops: bars*24 samples
      write_reg(REG_RATE, 32'd100);
      write_reg(REG_TEMPO, 32'd1000);
      write_reg(REG_BARS, 32'h00_03_02_01);
      write_reg(REG_PLAY, 32'hF);
      write_reg(REG_RECORD, 32'd0);
      write_reg(REG_ENABLE, 32'd1);
      for (int i = 0; i < 3; i++) send_sample(OUT_MAX, OUT_MIN, 48'd5);
      write_reg(REG_RECORD, 32'd1);
      send_sample(OUT_MIN, OUT_MAX, 48'd5);
      send_sample(24'sd1000, -24'sd1000, 48'd29);
      drain();
      // solo, then selectors out of range
      write_reg(REG_SOLO, 32'd1);
      send_sample(24'sd7, 24'sd9, 48'd53);
      write_reg(REG_SOLO, 32'd7);
      write_reg(REG_RECORD, 32'd5);
      send_sample(24'sd3, 24'sd4, 48'd5);
      write_reg(REG_SOLO, 32'd4);
      send_sample(24'sd3, 24'sd4, 48'd5);
      drain();
      // zero bars, zero tempo, fastest tempo, a rate of 384000
      write_reg(REG_BARS, 32'h00_00_00_00);
      write_reg(REG_RECORD, 32'd2);
      send_sample(24'sd11, 24'sd12, 48'd5);
      write_reg(REG_BARS, 32'hFF_FF_FF_FF);
      write_reg(REG_TEMPO, 32'd0);
      send_sample(24'sd13, 24'sd14, 48'd7);
      write_reg(REG_TEMPO, 32'd1023);
      write_reg(REG_RATE, 32'd384000);
      send_sample(24'sd15, 24'sd16, 48'd300000);
      send_sample(24'sd15, 24'sd16, 48'd7);
      drain();
      // clear taken only when the channel next plays
      write_reg(REG_BARS, 32'h00_03_02_01);
      write_reg(REG_RATE, 32'd100);
      write_reg(REG_TEMPO, 32'd1000);
      write_reg(REG_PLAY, 32'h0);
      write_reg(REG_CLEAR, 32'h3);
      send_sample(24'sd1, 24'sd2, 48'd5);
      write_reg(REG_PLAY, 32'h2);
      send_sample(24'sd1, 24'sd2, 48'd5);
      write_reg(REG_PLAY, 32'hF);
      send_sample(24'sd1, 24'sd2, 48'd5);
      drain();
   endtask

   task automatic random_config;
      write_reg(REG_ENABLE, ($urandom_range(9) != 0));
      write_reg(REG_SOLO, ($urandom_range(2) == 0) ? $urandom_range(7) : 4);
      write_reg(REG_RECORD, $urandom_range(7));
      write_reg(REG_TEMPO, $urandom_range(1023));
      write_reg(REG_RATE, ($urandom_range(7) == 0) ? $urandom_range(524287) : $urandom_range(1, 400));
      write_reg(REG_BARS, ($urandom_range(3) == 0) ? $urandom : ($urandom & 32'h0F0F0F0F));
      write_reg(REG_PLAY, $urandom_range(15));
   endtask

   task automatic test_random(input int idle, input int stall, input int count);
      logic [TIME_W-1:0] t;
      send_idle_pct = idle;
      stall_pct = stall;
      random_config();
      for (int i = 0; i < count; i++) begin
         t = ($urandom_range(9) == 0) ? rand_time() : TIME_W'($urandom_range(3000));
         send_sample($urandom, $urandom, t);
      end
      drain();
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   task automatic test_backpressure;
      @(posedge clock);
      hold_left = 4000;
      @(negedge clock);
      for (int i = 0; i < 8; i++) send_sample($urandom, $urandom, TIME_W'($urandom_range(200)));
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_left_in = '0;
      req_right_in = '0;
      req_time_index = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cycle_count = 0;
      error_count = 0;
      beats_sent = 0;
      beats_checked = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_left = 0;
      m_enable = 1'b0;
      m_solo = 3'd4;
      m_rec = 3'd4;
      m_bpm = 10'd120;
      m_rate = 19'd48000;
      m_bars = 32'd67372036;
      m_play = 4'h0;
      m_pend = 4'h0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_passthrough();
      test_record_play();
      for (int p = 0; p < 2; p++) begin
         test_random(0, 0, 50);
         test_random(63, 0, 50);
         test_random(0, 63, 50);
         test_random(10, 10, 50);
      end
      test_backpressure();

      drain();
      repeat (600) @(negedge clock);
      $display("covered pass-through, solo, overdub with saturation, clears and odd loop lengths");
      $display("%0d beats sent, %0d checked, %0d errors", beats_sent, beats_checked, error_count);
      if (error_count == 0 && mix_expected_q.size() == 0) begin
         $display("[tempo_synced_loop_overdub_mixer_unit] OK");
      end else begin
         $display("[tempo_synced_loop_overdub_mixer_unit] ERROR");
      end
      $finish;
   end

endmodule

// ===== tempo_synced_loop_overdub_mixer_unit.f =====
+incdir+hw/rtl
hw/rtl/tslom_pkg.sv
hw/rtl/tslom_div.sv
hw/rtl/tslom_dp.sv
hw/rtl/tslom_ctrl.sv
hw/rtl/tempo_synced_loop_overdub_mixer_unit.sv
tb/sv/tb_tempo_synced_loop_overdub_mixer_unit.sv
